// File: sv/art_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_pkg: shared definitions for the address range translator
// Command and status codes, table entry layout, sequencer states and the
// default table depth.
// ----------------------------------------------------------------------------
package art_pkg;

  // default number of table entries
  localparam int DEFAULT_ENTRIES = 16;

  // command codes
  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_ADD       = 2'd1;
  localparam logic [1:0] CMD_ERASE     = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNMAPPED  = 3'd1;
  localparam logic [2:0] ST_COLLISION = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // one table entry: [range_start, range_end) maps to host_start
  typedef struct packed {
    logic [63:0] host_start;
    logic [32:0] range_end;
    logic [31:0] range_start;
  } entry_t;

  // command sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: sv/art_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_table: range table storage
// Single-port-write, single-port-read synchronous memory holding one range
// entry per slot, with a registered read.
// ----------------------------------------------------------------------------
module art_table #(
  parameter int ENTRIES = art_pkg::DEFAULT_ENTRIES,
  parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  art_pkg::entry_t       wr_data,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  output art_pkg::entry_t       rd_data
);

  art_pkg::entry_t mem [ENTRIES];
  art_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/address_range_translator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_translator: guest to host address range translation table
// Holds up to ENTRIES guest ranges, each mapped to a 64-bit host base, and
// serves translate, add range and erase range commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command then
// keeps busy high through the scan and the result state: the table memory
// has one read port and is scanned one entry per cycle, followed by the
// registered read and the state in which the result is shown and any
// table update is written back. The single result beat is
// on out_status and out_result_addr for exactly one cycle, marked by
// out_valid, and cannot be held off, so the receiver must take it then.
// Valid bits are cleared by reset; every entry is read in each scan, but an entry counts only once written.
module address_range_translator #(
  parameter int ENTRIES = art_pkg::DEFAULT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_guest_addr,
  input  logic [31:0] in_range_length,
  input  logic [63:0] in_host_base,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [63:0] out_result_addr
);

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(ENTRIES);

  // sequencer
  art_pkg::state_t state_r, state_nxt;
  logic            accept;
  logic            rd_en;

  // command beat held for the whole scan
  logic [1:0]  cmd_r;
  logic [31:0] addr_r;
  logic [32:0] end_r;
  logic [63:0] host_r;

  // scan position and read pipeline
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IdxW-1:0] chk_idx_r;

  // scan results
  logic            hit_found_r, hit_found_nxt;
  logic [31:0]     hit_off_r, hit_off_nxt;
  logic [63:0]     hit_host_r, hit_host_nxt;
  logic            clash_r, clash_nxt;
  logic            exact_found_r, exact_found_nxt;
  logic [IdxW-1:0] exact_idx_r, exact_idx_nxt;
  logic            free_found_r, free_found_nxt;
  logic [IdxW-1:0] free_idx_r, free_idx_nxt;

  // valid bits
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  // table memory ports
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  art_pkg::entry_t  wr_data;
  art_pkg::entry_t  rd_data;

  // per-entry compare
  logic ent_valid;
  logic ent_free;
  logic ent_hit;
  logic ent_clash;
  logic ent_exact;

  // final decision
  logic [2:0]  res_status;
  logic [63:0] res_addr;
  logic        set_valid;
  logic        clr_valid;
  logic [IdxW-1:0] upd_idx;

  art_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IdxW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (cnt_r[IdxW-1:0]),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      art_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = art_pkg::ST_SCAN;
        end
      end
      art_pkg::ST_SCAN: begin
        if (cnt_r == LastCnt) begin
          state_nxt = art_pkg::ST_DONE;
        end
      end
      art_pkg::ST_DONE: begin
        state_nxt = art_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = art_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    accept    = 1'b0;
    rd_en     = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      art_pkg::ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      art_pkg::ST_SCAN: begin
        rd_en = (cnt_r != LastCnt);
      end
      art_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // compare the entry read in the previous cycle with the command
  always_comb begin
    ent_valid = chk_vld_r && valid_r[chk_idx_r];
    ent_free  = chk_vld_r && !valid_r[chk_idx_r];
    ent_hit   = ent_valid && (rd_data.range_start <= addr_r)
                && ({1'b0, addr_r} < rd_data.range_end);
    ent_clash = ent_valid && ({1'b0, addr_r} < rd_data.range_end)
                && ({1'b0, rd_data.range_start} < end_r);
    ent_exact = ent_valid && (rd_data.range_start == addr_r)
                && (rd_data.range_end == end_r);
  end

  // scan bookkeeping, first match of each kind wins
  always_comb begin
    cnt_nxt         = cnt_r;
    chk_vld_nxt     = 1'b0;
    hit_found_nxt   = hit_found_r;
    hit_off_nxt     = hit_off_r;
    hit_host_nxt    = hit_host_r;
    clash_nxt       = clash_r;
    exact_found_nxt = exact_found_r;
    exact_idx_nxt   = exact_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    if (accept) begin
      cnt_nxt         = '0;
      hit_found_nxt   = 1'b0;
      clash_nxt       = 1'b0;
      exact_found_nxt = 1'b0;
      free_found_nxt  = 1'b0;
    end else if (state_r == art_pkg::ST_SCAN) begin
      if (rd_en) begin
        cnt_nxt     = cnt_r + 1'b1;
        chk_vld_nxt = 1'b1;
      end
      if (ent_hit && !hit_found_r) begin
        hit_found_nxt = 1'b1;
        hit_off_nxt   = addr_r - rd_data.range_start;
        hit_host_nxt  = rd_data.host_start;
      end
      if (ent_clash) begin
        clash_nxt = 1'b1;
      end
      if (ent_exact && !exact_found_r) begin
        exact_found_nxt = 1'b1;
        exact_idx_nxt   = chk_idx_r;
      end
      if (ent_free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = chk_idx_r;
      end
    end
  end

  // result and table update for the finished command
  always_comb begin
    res_status = art_pkg::ST_OK;
    res_addr   = '0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    upd_idx    = exact_found_r ? exact_idx_r : free_idx_r;
    unique case (cmd_r)
      art_pkg::CMD_TRANSLATE: begin
        if (hit_found_r) begin
          res_addr = hit_host_r + {32'd0, hit_off_r};
        end else begin
          res_status = art_pkg::ST_UNMAPPED;
        end
      end
      art_pkg::CMD_ADD: begin
        if (clash_r) begin
          res_status = art_pkg::ST_COLLISION;
        end else if (exact_found_r || free_found_r) begin
          set_valid = 1'b1;
          res_addr  = {32'd0, addr_r};
        end else begin
          res_status = art_pkg::ST_FULL;
        end
      end
      art_pkg::CMD_ERASE: begin
        if (exact_found_r) begin
          clr_valid = 1'b1;
        end else begin
          res_status = art_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = art_pkg::ST_OK;
      end
    endcase
  end

  // write-back happens only in the result cycle, never during a scan
  assign wr_en   = out_valid && set_valid;
  assign wr_idx  = upd_idx;
  assign wr_data = '{host_start: host_r, range_end: end_r, range_start: addr_r};

  // valid bit update
  always_comb begin
    valid_nxt = valid_r;
    if (out_valid && set_valid) begin
      valid_nxt[upd_idx] = 1'b1;
    end
    if (out_valid && clr_valid) begin
      valid_nxt[upd_idx] = 1'b0;
    end
  end

  assign out_status      = res_status;
  assign out_result_addr = res_addr;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= art_pkg::ST_IDLE;
      valid_r   <= '0;
      chk_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      chk_vld_r <= chk_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // command beat and scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      addr_r <= in_guest_addr;
      end_r  <= {1'b0, in_guest_addr} + {1'b0, in_range_length};
      host_r <= in_host_base;
    end
    chk_idx_r     <= cnt_r[IdxW-1:0];
    hit_found_r   <= hit_found_nxt;
    hit_off_r     <= hit_off_nxt;
    hit_host_r    <= hit_host_nxt;
    clash_r       <= clash_nxt;
    exact_found_r <= exact_found_nxt;
    exact_idx_r   <= exact_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
  end

endmodule
